// ----- rtl/ypcb_pkg.sv -----
// Shared types, constants and the arctangent table for the camera basis core.
// No dependencies; every other file in rtl/ imports this package.
package ypcb_pkg;

  // CORDIC datapath: 30 fraction bits, two guard bits and a sign bit, rounded up.
  localparam int INNER_BITS = 30;
  localparam int CW         = 34;
  localparam int TABLE_LEN  = 24;

  // Start vector x, gain-compensated: round(K * 2^30).
  localparam logic signed [CW-1:0] GAIN_START = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cordic_lane_t;

  typedef struct packed {
    cordic_lane_t yaw;
    cordic_lane_t pitch;
  } cordic_pair_t;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } basis_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_turn(input int step);
    logic [31:0] val;
    case (step)
      0:       val = 32'h20000000;
      1:       val = 32'h12E4051E;
      2:       val = 32'h09FB385B;
      3:       val = 32'h051111D4;
      4:       val = 32'h028B0D43;
      5:       val = 32'h0145D7E1;
      6:       val = 32'h00A2F61E;
      7:       val = 32'h00517C55;
      8:       val = 32'h0028BE53;
      9:       val = 32'h00145F2F;
      10:      val = 32'h000A2F98;
      11:      val = 32'h000517CC;
      12:      val = 32'h00028BE6;
      13:      val = 32'h000145F3;
      14:      val = 32'h0000A2FA;
      15:      val = 32'h0000517D;
      16:      val = 32'h000028BE;
      17:      val = 32'h0000145F;
      18:      val = 32'h00000A30;
      19:      val = 32'h00000518;
      20:      val = 32'h0000028C;
      21:      val = 32'h00000146;
      22:      val = 32'h000000A3;
      23:      val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/ypcb_cordic_stage.sv -----
// One rotation-mode CORDIC iteration for the yaw and pitch lanes, registered.
// Depends on ypcb_pkg for the lane types and the arctangent table.
module ypcb_cordic_stage
  import ypcb_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         in_valid,
  input  cordic_pair_t in_data,
  output logic         out_valid,
  output cordic_pair_t out_data
);

  localparam logic signed [CW-1:0] ANGLE = CW'(atan_turn(STEP));

  function automatic cordic_lane_t rotate(input cordic_lane_t l);
    cordic_lane_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = l.y >>> STEP;
    dy = l.x >>> STEP;
    r  = l;
    if (l.z >= 0) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - ANGLE;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + ANGLE;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.yaw   <= rotate(in_data.yaw);
      out_data.pitch <= rotate(in_data.pitch);
    end
  end

endmodule

// ----- rtl/ypcb_sincos.sv -----
// Sine and cosine of yaw and pitch: quadrant fold, CORDIC stage chain, round and clamp.
// Depends on ypcb_pkg and ypcb_cordic_stage.
module ypcb_sincos
  import ypcb_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [15:0]                  yaw_angle,
  input  logic [15:0]                  pitch_angle,
  output logic                         out_valid,
  output logic signed [FRACTION_BITS+1:0] sy,
  output logic signed [FRACTION_BITS+1:0] cy,
  output logic signed [FRACTION_BITS+1:0] sp,
  output logic signed [FRACTION_BITS+1:0] cp
);

  localparam int TW = FRACTION_BITS + 2;
  localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int SH = INNER_BITS - FRACTION_BITS;
  localparam logic signed [CW-1:0] HALF = (CW'(1) << SH) >> 1;
  localparam logic signed [CW-1:0] UNIT = CW'(1) << FRACTION_BITS;

  cordic_pair_t chain_data  [NS+1];
  logic         chain_valid [NS+1];

  // Fold the second and third quadrants by half a turn; the fold is undone after.
  function automatic cordic_lane_t fold(input logic [15:0] ang);
    cordic_lane_t l;
    logic [31:0] a;
    a      = {ang[14], ang[14:0], 16'h0000};
    l.x    = GAIN_START;
    l.y    = '0;
    l.z    = CW'($signed(a));
    l.flip = ang[15] ^ ang[14];
    return l;
  endfunction

  function automatic logic signed [TW-1:0] round_clamp(input logic signed [CW-1:0] v,
                                                       input logic neg);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    t = neg ? -v : v;
    r = (t + HALF) >>> SH;
    if (r > UNIT) begin
      r = UNIT;
    end else if (r < -UNIT) begin
      r = -UNIT;
    end
    return TW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (adv) begin
      chain_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain_data[0].yaw   <= fold(yaw_angle);
      chain_data[0].pitch <= fold(pitch_angle);
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    ypcb_cordic_stage #(
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cy <= round_clamp(chain_data[NS].yaw.x,   chain_data[NS].yaw.flip);
      sy <= round_clamp(chain_data[NS].yaw.y,   chain_data[NS].yaw.flip);
      cp <= round_clamp(chain_data[NS].pitch.x, chain_data[NS].pitch.flip);
      sp <= round_clamp(chain_data[NS].pitch.y, chain_data[NS].pitch.flip);
    end
  end

endmodule

// ----- rtl/ypcb_basis.sv -----
// Forward, right and up vectors from the four trig values: product, cross product, pack.
// Depends on ypcb_pkg for the result struct.
module ypcb_basis
  import ypcb_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic signed [FRACTION_BITS+1:0] sy,
  input  logic signed [FRACTION_BITS+1:0] cy,
  input  logic signed [FRACTION_BITS+1:0] sp,
  input  logic signed [FRACTION_BITS+1:0] cp,
  output logic                            out_valid,
  output basis_t                          out_data
);

  localparam int TW = FRACTION_BITS + 2;
  localparam int VW = (TW + 1 > 16) ? TW + 1 : 16;
  localparam logic signed [TW:0] UNIT = (TW+1)'(1) << FRACTION_BITS;

  // Stage A: forward vector
  logic                 a_valid;
  logic signed [TW-1:0] a_sy, a_cy, a_sp, a_fx, a_fz;
  // Stage B: cross product terms
  logic                 b_valid;
  logic signed [TW-1:0] b_sy, b_cy, b_fx, b_fy, b_fz;
  logic signed [TW-1:0] b_ux, b_uy0, b_uy1, b_uz;

  logic signed [2*TW-1:0] p_fx, p_fz, p_ux, p_uy0, p_uy1, p_uz;
  logic signed [TW-1:0]   neg_sy_in, neg_sy_a;

  function automatic logic signed [15:0] pack(input logic signed [TW:0] v);
    logic signed [TW:0]   c;
    logic signed [VW-1:0] e;
    c = v;
    if (v > UNIT) begin
      c = UNIT;
    end else if (v < -UNIT) begin
      c = -UNIT;
    end
    e = VW'(c);
    return e[15:0];
  endfunction

  always_comb begin
    neg_sy_in = -sy;
    neg_sy_a  = -a_sy;
    p_fx      = cy * cp;
    p_fz      = neg_sy_in * cp;
    p_ux      = a_cy * a_sp;
    p_uy0     = neg_sy_a * a_fz;
    p_uy1     = a_cy * a_fx;
    p_uz      = a_sy * a_sp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sy  <= sy;
      a_cy  <= cy;
      a_sp  <= sp;
      a_fx  <= TW'(p_fx >>> FRACTION_BITS);
      a_fz  <= TW'(p_fz >>> FRACTION_BITS);

      b_sy  <= a_sy;
      b_cy  <= a_cy;
      b_fx  <= a_fx;
      b_fy  <= a_sp;
      b_fz  <= a_fz;
      b_ux  <= -TW'(p_ux >>> FRACTION_BITS);
      b_uy0 <= TW'(p_uy0 >>> FRACTION_BITS);
      b_uy1 <= TW'(p_uy1 >>> FRACTION_BITS);
      b_uz  <= TW'(p_uz >>> FRACTION_BITS);

      out_data.fwd_x   <= pack((TW+1)'(b_fx));
      out_data.fwd_y   <= pack((TW+1)'(b_fy));
      out_data.fwd_z   <= pack((TW+1)'(b_fz));
      out_data.right_x <= pack((TW+1)'(b_sy));
      out_data.right_z <= pack((TW+1)'(b_cy));
      out_data.up_x    <= pack((TW+1)'(b_ux));
      out_data.up_y    <= pack((TW+1)'(b_uy0) + (TW+1)'(b_uy1));
      out_data.up_z    <= pack((TW+1)'(b_uz));
    end
  end

endmodule

// ----- rtl/yaw_pitch_camera_basis_core.sv -----
// Top level of the yaw/pitch camera basis core: sincos pipeline, basis math, output buffer.
// Depends on ypcb_pkg, ypcb_sincos and ypcb_basis.
//
//   channel  valid      stall      payload
//   request  req_valid  req_stall  yaw_angle, pitch_angle
//   result   rsp_valid  rsp_stall  fwd_x/y/z, right_x/z, up_x/y/z
//
// One item enters per cycle while req_stall is low. The registers, in order: angle fold,
// one stage per CORDIC iteration, round/clamp, forward products, cross-product terms,
// final pack, and the output register.
// Reset clears only valid bits and the skid flag; payload registers carry no reset.
// The whole pipeline advances together while the skid entry is empty. A result stalled at
// the output parks the next result in the skid entry, and req_stall rises from that flag.
module yaw_pitch_camera_basis_core
  import ypcb_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [15:0]        yaw_angle,
  input  logic [15:0]        pitch_angle,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [15:0] fwd_x,
  output logic signed [15:0] fwd_y,
  output logic signed [15:0] fwd_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);

  localparam int TW = FRACTION_BITS + 2;

  logic                 adv;        // pipeline moves this cycle
  logic                 out_free;   // output register can take a new item
  logic                 trig_valid;
  logic signed [TW-1:0] sy, cy, sp, cp;
  logic                 head_valid;
  basis_t               head_data;
  logic                 skid_full;
  basis_t               skid_data;
  basis_t               rsp_data;

  // Advance everything unless a result is parked in the skid entry.
  assign adv       = ~skid_full;
  assign req_stall = skid_full;
  assign out_free  = ~rsp_valid | ~rsp_stall;

  ypcb_sincos #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_sincos (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (req_valid),
    .yaw_angle   (yaw_angle),
    .pitch_angle (pitch_angle),
    .out_valid   (trig_valid),
    .sy          (sy),
    .cy          (cy),
    .sp          (sp),
    .cp          (cp)
  );

  ypcb_basis #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_basis (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (trig_valid),
    .sy        (sy),
    .cy        (cy),
    .sp        (sp),
    .cp        (cp),
    .out_valid (head_valid),
    .out_data  (head_data)
  );

  // Output register plus one skid entry. While the pipe advances, its head item leaves
  // and must land somewhere: the output register if free, else the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (adv) begin
      if (out_free) begin
        rsp_valid <= head_valid;
      end else if (head_valid) begin
        skid_full <= 1'b1;
      end
    end else if (out_free) begin
      // Drain the skid entry; the pipe restarts next cycle.
      rsp_valid <= 1'b1;
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (out_free) begin
        rsp_data <= head_data;
      end else begin
        skid_data <= head_data;
      end
    end else if (out_free) begin
      rsp_data <= skid_data;
    end
  end

  assign fwd_x   = rsp_data.fwd_x;
  assign fwd_y   = rsp_data.fwd_y;
  assign fwd_z   = rsp_data.fwd_z;
  assign right_x = rsp_data.right_x;
  assign right_z = rsp_data.right_z;
  assign up_x    = rsp_data.up_x;
  assign up_y    = rsp_data.up_y;
  assign up_z    = rsp_data.up_z;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for yaw_pitch_camera_basis_core: streams yaw/pitch items and
// checks every basis result against an in-bench CORDIC and cross-product predictor.
// Depends on rtl/ypcb_pkg.sv and rtl/yaw_pitch_camera_basis_core.sv.
module tb_top;
  import ypcb_pkg::*;

  localparam int  STEPS       = 16;
  localparam int  FRAC        = 14;
  localparam int  CORDIC_FRAC = 30;
  localparam int  ROUND_SHIFT = CORDIC_FRAC - FRAC;
  localparam int  ATAN_LEN    = 24;
  localparam longint GAIN_X0  = 64'sd652032874;
  localparam int  LATENCY     = 22;
  localparam int  IDLE_PCT    = 31;
  localparam int  HANG_LIMIT  = 4000;
  localparam int  REPORT_MAX  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               req_valid   = 1'b0;
  logic               req_stall;
  logic [15:0]        yaw_angle   = '0;
  logic [15:0]        pitch_angle = '0;
  logic               rsp_valid;
  logic               rsp_stall   = 1'b0;
  logic signed [15:0] fwd_x, fwd_y, fwd_z, right_x, right_z, up_x, up_y, up_z;

  // Expected bases in acceptance order; the oldest is at the front.
  basis_t pending_basis[$];
  int     fault_count = 0;
  int     hang_cycles = 0;
  // While set, neither side idles: gives a stretch of full-rate traffic.
  bit     no_idle     = 1'b0;

  yaw_pitch_camera_basis_core dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .yaw_angle  (yaw_angle),
    .pitch_angle(pitch_angle),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .fwd_x      (fwd_x),
    .fwd_y      (fwd_y),
    .fwd_z      (fwd_z),
    .right_x    (right_x),
    .right_z    (right_z),
    .up_x       (up_x),
    .up_y       (up_y),
    .up_z       (up_z)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Arctangent of 2^-i in 32-bit turns.
  function automatic longint atan_step(input int i);
    case (i)
      0:       return 64'h20000000;
      1:       return 64'h12E4051E;
      2:       return 64'h09FB385B;
      3:       return 64'h051111D4;
      4:       return 64'h028B0D43;
      5:       return 64'h0145D7E1;
      6:       return 64'h00A2F61E;
      7:       return 64'h00517C55;
      8:       return 64'h0028BE53;
      9:       return 64'h00145F2F;
      10:      return 64'h000A2F98;
      11:      return 64'h000517CC;
      12:      return 64'h00028BE6;
      13:      return 64'h000145F3;
      14:      return 64'h0000A2FA;
      15:      return 64'h0000517D;
      16:      return 64'h000028BE;
      17:      return 64'h0000145F;
      18:      return 64'h00000A30;
      19:      return 64'h00000518;
      20:      return 64'h0000028C;
      21:      return 64'h00000146;
      22:      return 64'h000000A3;
      23:      return 64'h00000051;
      default: return 64'h0;
    endcase
  endfunction

  function automatic longint clamp_unit(input longint v);
    longint one;
    one = longint'(1) <<< FRAC;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // Fixed-point product, floor shift back to FRAC fraction bits.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic logic signed [15:0] to_field(input longint v);
    longint t;
    t = clamp_unit(v);
    return t[15:0];
  endfunction

  // Rotation-mode CORDIC on a 32-bit turn; fold the left half-plane onto the right one.
  task automatic cordic_sincos(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] turn;
    bit          fold;
    longint      x, y, z, dx, dy;
    int          i;
    turn = {ang, 16'h0000};
    fold = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (fold) turn = turn - 32'h8000_0000;
    z = longint'($signed(turn));
    x = GAIN_X0;
    y = 0;
    for (i = 0; i < STEPS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end
    end
    if (fold) begin
      x = -x;
      y = -y;
    end
    x = (x + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    y = (y + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    c = clamp_unit(x);
    s = clamp_unit(y);
  endtask

  // Forward, right and up vectors; up is built term by term from the rounded vectors.
  task automatic camera_basis(input logic [15:0] yaw, input logic [15:0] pitch,
                              output basis_t b);
    longint sy, cy, sp, cp, fx, fy, fz;
    cordic_sincos(yaw, sy, cy);
    cordic_sincos(pitch, sp, cp);
    fx = clamp_unit(qmul(cy, cp));
    fy = sp;
    fz = clamp_unit(qmul(-sy, cp));
    b.fwd_x   = to_field(fx);
    b.fwd_y   = to_field(fy);
    b.fwd_z   = to_field(fz);
    b.right_x = to_field(sy);
    b.right_z = to_field(cy);
    b.up_x    = to_field(qmul(0, fz) - qmul(cy, fy));
    b.up_y    = to_field(qmul(-sy, fz) + qmul(cy, fx));
    b.up_z    = to_field(qmul(sy, fy) - qmul(0, fx));
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one item at the falling edge, hold it until accepted, then record its basis.
  // Idle cycles lower valid in their own time steps, so valid never toggles within one.
  task automatic send_angles(input logic [15:0] yaw, input logic [15:0] pitch);
    basis_t b;
    @(negedge clk);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid   <= 1'b1;
    yaw_angle   <= yaw;
    pitch_angle <= pitch;
    do @(posedge clk); while (req_stall);
    camera_basis(yaw, pitch, b);
    pending_basis.push_back(b);
  endtask

  // Drop valid and hold off until every expected basis has come back.
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_basis.size() != 0) @(posedge clk);
  endtask

  // Angle near a quadrant boundary, wrapping around zero.
  function automatic logic [15:0] near_quadrant();
    logic [15:0] base;
    base = 16'($urandom_range(3)) << 14;
    return base + 16'($urandom_range(128)) - 16'd64;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result channel at random, except during a full-rate stretch.
  always @(negedge clk) begin
    rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic check_field(input string name, input logic signed [15:0] exp_v,
                             input logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      fault_count++;
      if (fault_count <= REPORT_MAX)
        $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  // Compare each accepted result against the oldest expected basis.
  always @(posedge clk) begin
    basis_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_basis.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected result: fwd_x %0d fwd_y %0d fwd_z %0d", fwd_x, fwd_y, fwd_z);
      end else begin
        want = pending_basis.pop_front();
        check_field("fwd_x", want.fwd_x, fwd_x);
        check_field("fwd_y", want.fwd_y, fwd_y);
        check_field("fwd_z", want.fwd_z, fwd_z);
        check_field("right_x", want.right_x, right_x);
        check_field("right_z", want.right_z, right_z);
        check_field("up_x", want.up_x, up_x);
        check_field("up_y", want.up_y, up_y);
        check_field("up_z", want.up_z, up_z);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", HANG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, quadrant edges, exact zero angles and each octant.
  task automatic test_directed();
    send_angles(16'h0000, 16'h0000);
    send_angles(16'hFFFF, 16'hFFFF);
    send_angles(16'h4000, 16'h0000);
    send_angles(16'h8000, 16'h0000);
    send_angles(16'hC000, 16'h0000);
    send_angles(16'h0000, 16'h4000);
    send_angles(16'h0000, 16'h8000);
    send_angles(16'h0000, 16'hC000);
    send_angles(16'h3FFF, 16'h4001);
    send_angles(16'h7FFF, 16'h8001);
    send_angles(16'hBFFF, 16'hC001);
    send_angles(16'h2000, 16'h2000);
    send_angles(16'h6000, 16'hE000);
    send_angles(16'hA000, 16'h6000);
    send_angles(16'hE000, 16'hA000);
    send_angles(16'h0001, 16'hFFFF);
    send_angles(16'hFFFF, 16'h0001);
    send_angles(16'h5555, 16'hAAAA);
    send_angles(16'hAAAA, 16'h5555);
    send_angles(16'h4000, 16'h4000);
    send_angles(16'hC000, 16'hC000);
    send_angles(16'h8000, 16'h8000);
    send_angles(16'h1234, 16'hFEDC);
  endtask

  // Uniform random angles with idling on both sides.
  task automatic test_random_stream(input int count);
    repeat (count) send_angles(16'($urandom), 16'($urandom));
  endtask

  // Full-rate stretch: no idling on either side.
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) send_angles(16'($urandom), 16'($urandom));
    no_idle = 1'b0;
  endtask

  // Angles clustered around the quadrant boundaries, which include the fold boundaries of the sine/cosine reduction.
  task automatic test_quadrant_edges(input int count);
    repeat (count) begin
      if ($urandom_range(1))
        send_angles(near_quadrant(), near_quadrant());
      else
        send_angles(near_quadrant(), 16'($urandom));
    end
  endtask

  // Bursts separated by a full drain of the pipeline.
  task automatic test_drain_bursts(input int bursts, input int per_burst);
    repeat (bursts) begin
      repeat (per_burst) send_angles(16'($urandom), 16'($urandom));
      wait_drained();
    end
  endtask

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_stream(250);
    test_back_to_back(150);
    test_quadrant_edges(120);
    test_drain_bursts(4, 25);

    // Drain, then give the pipeline time to show any stray result.
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (fault_count == 0 && pending_basis.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
